[src/wfv_pkg.sv]
`default_nettype none
package wfv_pkg;

	localparam int MAX_WAYPOINTS_DEF = 64;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_POSE   = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;

	localparam logic [2:0] NS_IDLE      = 3'd0;
	localparam logic [2:0] NS_NAV       = 3'd1;
	localparam logic [2:0] NS_REACHED   = 3'd2;
	localparam logic [2:0] NS_CANCELLED = 3'd3;
	localparam logic [2:0] NS_ABORTED   = 3'd4;

	localparam logic [2:0] CFG_MAX_LIN  = 3'd0;
	localparam logic [2:0] CFG_MAX_ANG  = 3'd1;
	localparam logic [2:0] CFG_GOAL_TOL = 3'd2;
	localparam logic [2:0] CFG_WP_TOL   = 3'd3;
	localparam logic [2:0] CFG_HEAD_THR = 3'd4;

	localparam logic [12:0] RST_MAX_LIN  = 13'd1229;
	localparam logic [13:0] RST_MAX_ANG  = 14'd3277;
	localparam logic [12:0] RST_GOAL_TOL = 13'd154;
	localparam logic [12:0] RST_WP_TOL   = 13'd256;
	localparam logic [13:0] RST_HEAD_THR = 14'd2048;

	localparam logic signed [17:0] PI_Q12      = 18'sd12868;
	localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
	localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
	localparam logic signed [19:0] PI_Q16      = 20'sd205887;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd39797;
	localparam logic [16:0]        COS_ONE     = 17'd65536;
	localparam logic [10:0]        FINAL_CAP   = 11'd328;

	typedef logic signed [31:0] cxy_t;
	typedef logic signed [19:0] cz_t;

	typedef struct packed {
		logic start;
		logic rotate;
	} cordic_ctl_t;

	function automatic logic [15:0] ang_tab(input logic [3:0] i);
		logic [15:0] v;
		case (i)
			4'd0:  v = 16'd51472;
			4'd1:  v = 16'd30386;
			4'd2:  v = 16'd16055;
			4'd3:  v = 16'd8150;
			4'd4:  v = 16'd4091;
			4'd5:  v = 16'd2047;
			4'd6:  v = 16'd1024;
			4'd7:  v = 16'd512;
			4'd8:  v = 16'd256;
			4'd9:  v = 16'd128;
			4'd10: v = 16'd64;
			4'd11: v = 16'd32;
			4'd12: v = 16'd16;
			4'd13: v = 16'd8;
			4'd14: v = 16'd4;
			default: v = 16'd2;
		endcase
		return v;
	endfunction

	function automatic logic signed [14:0] clamp_sym(input logic signed [19:0] v,
			input logic [13:0] lim);
		logic signed [19:0] l;
		logic signed [19:0] r;
		l = signed'(20'(lim));
		if (v > l)
			r = l;
		else if (v < -l)
			r = -l;
		else
			r = v;
		return 15'(r);
	endfunction

endpackage
`default_nettype wire

[src/wfv_cordic.sv]
`default_nettype none
module wfv_cordic (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wfv_pkg::cordic_ctl_t     ctl,
	input  wfv_pkg::cxy_t            x0,
	input  wfv_pkg::cxy_t            y0,
	input  wfv_pkg::cz_t             z0,
	output logic                     done,
	output wfv_pkg::cxy_t            x,
	output wfv_pkg::cz_t             z
);

	wfv_pkg::cxy_t x_q, y_q, xs, ys;
	wfv_pkg::cz_t  z_q, a;
	logic [3:0]    it_q;
	logic          busy_q, rot_q, done_q;
	logic          dir;

	assign xs  = x_q >>> it_q;
	assign ys  = y_q >>> it_q;
	assign a   = signed'(20'(wfv_pkg::ang_tab(it_q)));
	// dir high: rotate counterclockwise
	assign dir = rot_q ? (z_q >= 0) : (y_q < 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
			rot_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
				rot_q  <= ctl.rotate;
			end else if (busy_q) begin
				it_q <= it_q + 4'd1;
				if (it_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			if (!ctl.rotate && x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (y0 >= 0) ? wfv_pkg::PI_Q16 : -wfv_pkg::PI_Q16;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= z0;
			end
		end else if (busy_q) begin
			if (dir) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= rot_q ? z_q - a : z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign z    = z_q;

endmodule
`default_nettype wire

[src/wfv_div.sv]
`default_nettype none
module wfv_div (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	input  wire  [47:0]  n,
	input  wire  [47:0]  d,
	output logic         done,
	output logic [10:0]  q
);

	logic [47:0] r_q, dsh_q;
	logic [10:0] q_q;
	logic [3:0]  k_q;
	logic        busy_q, done_q;
	logic        ge;

	assign ge = (r_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 4'd1;
				if (k_q == 4'd10) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring, 11 quotient bits; anything above 328 saturates downstream
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= n;
			dsh_q <= {d[37:0], 10'b0};
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge)
				r_q <= r_q - dsh_q;
			q_q   <= {q_q[9:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule
`default_nettype wire

[src/waypoint_follower_velocity_top.sv]
// Channel  | Signals                                         | Direction
// in       | in_valid/in_ready, operation, pos_x/y, heading,  | into block
//          | final_waypoint                                  |
// out      | out_valid/out_ready, linear_cmd, angular_cmd,   | out of block
//          | nav_status                                      |
// cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data        | into block
//
// Append and cancel are handled in the idle state. A pose tick makes a goal
// decision, then either walks the waypoints or takes the final leg, with a
// CORDIC pass for atan2, then possibly one more for cosine, or the divider.
// One item at a time: in_ready is low while an item works or a result waits.
// arst_n clears control state and loads the register defaults.
`default_nettype none
module waypoint_follower_velocity_top #(
	parameter int MAX_WAYPOINTS = wfv_pkg::MAX_WAYPOINTS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire         [1:0]  operation,
	input  wire  signed [15:0] pos_x,
	input  wire  signed [15:0] pos_y,
	input  wire  signed [14:0] heading,
	input  wire                final_waypoint,
	output logic               out_valid,
	input  wire                out_ready,
	output logic        [12:0] linear_cmd,
	output logic signed [14:0] angular_cmd,
	output logic        [2:0]  nav_status,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire         [2:0]  cfg_index,
	input  wire         [13:0] cfg_data
);

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_GX   = 5'd1;
	localparam logic [4:0] S_GY   = 5'd2;
	localparam logic [4:0] S_GSUM = 5'd3;
	localparam logic [4:0] S_GCMP = 5'd4;
	localparam logic [4:0] S_FAT  = 5'd5;
	localparam logic [4:0] S_FCHK = 5'd6;
	localparam logic [4:0] S_FMUL = 5'd7;
	localparam logic [4:0] S_FDIV = 5'd8;
	localparam logic [4:0] S_WRD  = 5'd9;
	localparam logic [4:0] S_WDX  = 5'd10;
	localparam logic [4:0] S_WDY  = 5'd11;
	localparam logic [4:0] S_WCMP = 5'd12;
	localparam logic [4:0] S_WAT  = 5'd13;
	localparam logic [4:0] S_WCHK = 5'd14;
	localparam logic [4:0] S_WCOS = 5'd15;
	localparam logic [4:0] S_WLIN = 5'd16;

	logic [4:0] state_q;

	logic [12:0] mls_q, gtol_q, wtol_q;
	logic [13:0] mas_q, thr_q, lim3_q;
	logic [25:0] gt2_q, wt2_q;
	logic [15:0] lim3_v;

	logic [31:0] wp_mem [MAX_WAYPOINTS];
	logic [31:0] rd_q;
	logic        wr_en;
	logic [AW-1:0] wr_addr;

	logic [CW-1:0] count_q, cnt_eff;
	logic [AW-1:0] ti_q;
	logic          active_q, loading_q;

	logic signed [15:0] px_q, py_q, goal_x_q, goal_y_q;
	logic signed [14:0] hd_q;
	logic [33:0]        d2_q, d2w_q;
	logic signed [17:0] e_q, e_raw, e_c, abs_e;
	logic signed [15:0] at16;
	logic               zvec_q;

	logic signed [17:0] mul_a;
	logic signed [30:0] mul_b;
	logic signed [48:0] prod_q;

	logic signed [16:0] dxg, dyg, dxw, dyw, dx_sel, dy_sel;
	logic signed [17:0] thr_s;
	logic [33:0]        gt2_34, d2w_sum;
	logic [47:0]        div_n, div_d;
	logic [18:0]        rot_mag;
	logic signed [19:0] rot_ang;
	logic [16:0]        cos_c;
	logic [13:0]        lin_c;

	logic                  out_valid_q;
	logic [12:0]           lin_q;
	logic signed [14:0]    ang_q;
	logic [2:0]            st_q;

	wfv_pkg::cordic_ctl_t  cctl;
	wfv_pkg::cxy_t         cx0, cy0, cord_x;
	wfv_pkg::cz_t          cz0, cord_z;
	logic                  cord_done;
	logic                  div_start, div_done;
	logic [10:0]           div_q;

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;

	assign dxg = 17'(goal_x_q) - 17'(px_q);
	assign dyg = 17'(goal_y_q) - 17'(py_q);
	assign dxw = 17'(signed'(rd_q[31:16])) - 17'(px_q);
	assign dyw = 17'(signed'(rd_q[15:0])) - 17'(py_q);
	assign dx_sel = (state_q == S_GCMP) ? dxg : dxw;
	assign dy_sel = (state_q == S_GCMP) ? dyg : dyw;

	assign gt2_34  = 34'(gt2_q);
	assign d2w_sum = d2w_q + prod_q[33:0];
	assign div_n   = {prod_q[46:0], 1'b0} + 48'(gt2_34 * 34'd90);
	assign div_d   = 48'(gt2_34 * 34'd180);
	assign cnt_eff = loading_q ? count_q : '0;

	assign at16  = zvec_q ? 16'sd0 : 16'((cord_z + 20'sd8) >>> 4);
	assign e_raw = 18'(at16) - 18'(hd_q);
	always_comb begin
		if (e_raw > wfv_pkg::PI_Q12)
			e_c = e_raw - wfv_pkg::TWO_PI_Q12;
		else if (e_raw < -wfv_pkg::PI_Q12)
			e_c = e_raw + wfv_pkg::TWO_PI_Q12;
		else
			e_c = e_raw;
	end

	assign abs_e   = (e_q < 0) ? -e_q : e_q;
	assign thr_s   = signed'(18'(thr_q));
	assign rot_mag = 19'((19'(abs_e[16:0]) * 19'd3) >> 1);
	assign rot_ang = (e_q < 0) ? -signed'(20'(rot_mag)) : signed'(20'(rot_mag));

	always_comb begin
		if (cord_x < 0)
			cos_c = '0;
		else if (cord_x > 32'sd65536)
			cos_c = wfv_pkg::COS_ONE;
		else
			cos_c = cord_x[16:0];
	end
	assign lin_c = 14'((prod_q[30:0] + 31'd32768) >> 16);

	assign lim3_v = 16'(mas_q) * 16'd3 + 16'd5;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_GX: begin
				mul_a = 18'(dxg);
				mul_b = 31'(dxg);
			end
			S_GY: begin
				mul_a = 18'(dyg);
				mul_b = 31'(dyg);
			end
			S_WDX: begin
				mul_a = 18'(dxw);
				mul_b = 31'(dxw);
			end
			S_WDY: begin
				mul_a = 18'(dyw);
				mul_b = 31'(dyw);
			end
			S_FCHK: begin
				mul_a = signed'(18'(16'(mls_q) * 16'd3));
				mul_b = signed'({1'b0, d2_q[29:0]});
			end
			S_WCOS: begin
				mul_a = signed'({1'b0, cos_c});
				mul_b = signed'(31'(mls_q));
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cctl.start  = 1'b0;
		cctl.rotate = 1'b0;
		cx0 = 32'(dx_sel) <<< 12;
		cy0 = 32'(dy_sel) <<< 12;
		cz0 = '0;
		div_start = (state_q == S_FMUL);
		if (state_q == S_GCMP)
			cctl.start = (d2_q >= gt2_34) && (d2_q < gt2_34 * 34'd9);
		else if (state_q == S_WCMP)
			cctl.start = !((CW'(ti_q) + 1'b1 < count_q) && (d2w_sum < 34'(wt2_q)));
		else if (state_q == S_WCHK) begin
			cctl.start  = !(e_q > thr_s || e_q < -thr_s) &&
				!(e_q > wfv_pkg::HALF_PI_Q12 || e_q < -wfv_pkg::HALF_PI_Q12);
			cctl.rotate = 1'b1;
			cx0 = wfv_pkg::CORDIC_GAIN;
			cy0 = '0;
			cz0 = 20'(e_q) <<< 4;
		end
	end

	wfv_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.done   (cord_done),
		.x      (cord_x),
		.z      (cord_z)
	);

	wfv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_done),
		.q      (div_q)
	);

	assign wr_en   = in_valid && in_ready && (operation == wfv_pkg::OP_APPEND) &&
		(final_waypoint || (cnt_eff < CW'(MAX_WAYPOINTS - 1)));
	assign wr_addr = cnt_eff[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en)
			wp_mem[wr_addr] <= {pos_x, pos_y};
		if (state_q == S_WRD)
			rd_q <= wp_mem[ti_q];
	end

	always_ff @(posedge clk) begin
		prod_q <= 49'(mul_a * mul_b);
		gt2_q  <= gtol_q * gtol_q;
		wt2_q  <= wtol_q * wtol_q;
		lim3_q <= 14'((32'(lim3_v) * 32'd52429) >> 19);
		if (in_valid && in_ready) begin
			px_q <= pos_x;
			py_q <= pos_y;
			hd_q <= heading;
		end
		if (state_q == S_GY)
			d2_q <= prod_q[33:0];
		if (state_q == S_GSUM)
			d2_q <= d2_q + prod_q[33:0];
		if (state_q == S_WDY)
			d2w_q <= prod_q[33:0];
		if (cctl.start && !cctl.rotate)
			zvec_q <= (dx_sel == 17'sd0) && (dy_sel == 17'sd0);
		if ((state_q == S_FAT || state_q == S_WAT) && cord_done)
			e_q <= e_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mls_q  <= wfv_pkg::RST_MAX_LIN;
			mas_q  <= wfv_pkg::RST_MAX_ANG;
			gtol_q <= wfv_pkg::RST_GOAL_TOL;
			wtol_q <= wfv_pkg::RST_WP_TOL;
			thr_q  <= wfv_pkg::RST_HEAD_THR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wfv_pkg::CFG_MAX_LIN:  mls_q  <= cfg_data[12:0];
				wfv_pkg::CFG_MAX_ANG:  mas_q  <= cfg_data;
				wfv_pkg::CFG_GOAL_TOL: gtol_q <= cfg_data[12:0];
				wfv_pkg::CFG_WP_TOL:   wtol_q <= cfg_data[12:0];
				wfv_pkg::CFG_HEAD_THR: thr_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ti_q        <= '0;
			active_q    <= 1'b0;
			loading_q   <= 1'b0;
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			out_valid_q <= 1'b0;
			lin_q       <= '0;
			ang_q       <= '0;
			st_q        <= wfv_pkg::NS_IDLE;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						case (operation)
							wfv_pkg::OP_APPEND: begin
								if (!loading_q) begin
									ti_q     <= '0;
									active_q <= 1'b0;
								end
								if (!final_waypoint) begin
									loading_q <= 1'b1;
									count_q   <= (cnt_eff < CW'(MAX_WAYPOINTS - 1)) ?
										cnt_eff + 1'b1 : cnt_eff;
								end else begin
									count_q     <= cnt_eff + 1'b1;
									goal_x_q    <= pos_x;
									goal_y_q    <= pos_y;
									ti_q        <= '0;
									active_q    <= 1'b1;
									loading_q   <= 1'b0;
									lin_q       <= '0;
									ang_q       <= '0;
									st_q        <= wfv_pkg::NS_NAV;
									out_valid_q <= 1'b1;
								end
							end
							wfv_pkg::OP_CANCEL: begin
								active_q    <= 1'b0;
								loading_q   <= 1'b0;
								count_q     <= '0;
								ti_q        <= '0;
								lin_q       <= '0;
								ang_q       <= '0;
								st_q        <= wfv_pkg::NS_CANCELLED;
								out_valid_q <= 1'b1;
							end
							wfv_pkg::OP_POSE: begin
								if (active_q && count_q != '0)
									state_q <= S_GX;
							end
							default: begin
							end
						endcase
					end
				end
				S_GX:   state_q <= S_GY;
				S_GY:   state_q <= S_GSUM;
				S_GSUM: state_q <= S_GCMP;
				S_GCMP: begin
					if (d2_q < gt2_34) begin
						active_q    <= 1'b0;
						lin_q       <= '0;
						ang_q       <= '0;
						st_q        <= wfv_pkg::NS_REACHED;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (cctl.start)
						state_q <= S_FAT;
					else
						state_q <= S_WRD;
				end
				S_FAT: begin
					if (cord_done)
						state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (e_q > wfv_pkg::HALF_PI_Q12 || e_q < -wfv_pkg::HALF_PI_Q12) begin
						active_q    <= 1'b0;
						lin_q       <= '0;
						ang_q       <= '0;
						st_q        <= wfv_pkg::NS_ABORTED;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else
						state_q <= S_FMUL;
				end
				S_FMUL: state_q <= S_FDIV;
				S_FDIV: begin
					if (div_done) begin
						lin_q       <= 13'((div_q > wfv_pkg::FINAL_CAP) ?
							wfv_pkg::FINAL_CAP : div_q);
						ang_q       <= wfv_pkg::clamp_sym(20'(e_q), lim3_q);
						st_q        <= wfv_pkg::NS_NAV;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_WRD: state_q <= S_WDX;
				S_WDX: state_q <= S_WDY;
				S_WDY: state_q <= S_WCMP;
				S_WCMP: begin
					if (cctl.start)
						state_q <= S_WAT;
					else begin
						ti_q    <= ti_q + 1'b1;
						state_q <= S_WRD;
					end
				end
				S_WAT: begin
					if (cord_done)
						state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (e_q > thr_s || e_q < -thr_s) begin
						lin_q       <= '0;
						ang_q       <= wfv_pkg::clamp_sym(rot_ang, mas_q);
						st_q        <= wfv_pkg::NS_NAV;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (!cctl.start) begin
						lin_q       <= '0;
						ang_q       <= wfv_pkg::clamp_sym(20'(e_q) <<< 1, mas_q);
						st_q        <= wfv_pkg::NS_NAV;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else
						state_q <= S_WCOS;
				end
				S_WCOS: begin
					if (cord_done)
						state_q <= S_WLIN;
				end
				S_WLIN: begin
					lin_q       <= (lin_c > 14'(mls_q)) ? mls_q : lin_c[12:0];
					ang_q       <= wfv_pkg::clamp_sym(20'(e_q) <<< 1, mas_q);
					st_q        <= wfv_pkg::NS_NAV;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign linear_cmd  = lin_q;
	assign angular_cmd = ang_q;
	assign nav_status  = st_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result waits");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WAYPOINTS))
		else $error("waypoint count beyond capacity");

	a_active_list: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (count_q != '0) && (CW'(ti_q) < count_q))
		else $error("navigating without a valid target");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WCMP && !cctl.start) |=> (CW'(ti_q) + 1'b1 <= count_q - 1'b1) ||
		(CW'(ti_q) < count_q))
		else $error("waypoint walk ran past the goal");

endmodule
`default_nettype wire
